/* rtl/rtps_pkg.sv */
// shared types, codes and defaults for the rtp sender with retransmission cache
package rtps_pkg;

    // default sizes
    localparam int CACHE_DEPTH_DEF = 256;
    localparam int TYPE_SLOTS_DEF  = 4;
    localparam int TABLE_BYTES     = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCAL_SSRC   = 3'd0,
        REG_RTX_SSRC     = 3'd1,
        REG_RTX_ENABLED  = 3'd2,
        REG_CACHE_WINDOW = 3'd3,
        REG_MEDIA_TABLE  = 3'd4,
        REG_RTX_TABLE    = 3'd5,
        REG_RTX_FIRST    = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        STAT_SENT          = 3'd0,
        STAT_SSRC_MISMATCH = 3'd1,
        STAT_UNKNOWN_TYPE  = 3'd2,
        STAT_SEQ_GAP       = 3'd3,
        STAT_RTX_SENT      = 3'd4,
        STAT_NOT_CACHED    = 3'd5,
        STAT_RTX_OFF       = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_ADDR,
        ST_EXEC
    } t_state;

    // one cached packet header
    typedef struct packed {
        logic [15:0] seq;
        logic        marker;
        logic [6:0]  ptype;
        logic [31:0] media_time;
        logic [15:0] handle;
        logic [15:0] length;
    } t_cache_entry;

    // result of a payload type lookup
    typedef struct packed {
        logic       known;
        logic       rtx_valid;
        logic [6:0] rtx_type;
    } t_type_match;

endpackage

/* rtl/rtp_sender_with_rtx_cache_top.sv */
// rtp sender: send checks, counters and an rtx header cache held in ram
// the result strobe is registered after the execute step; when CACHE_DEPTH is not a power
//   of two, slot = sequence mod depth takes two extra steps, quotient then address
// requests: busy holds off a new one until the last has done its cache ram read and write back
// reset: synchronous, active low; afterwards a clearing pass over all CACHE_DEPTH entries resets the
//   valid ram, busy stays high for it; results are shown for one cycle, no stall
module rtp_sender_with_rtx_cache_top
    import rtps_pkg::*;
#(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
    parameter int TYPE_SLOTS  = TYPE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [31:0]           i_source_id,
    input  logic [15:0]           i_sequence_req,
    input  logic [6:0]            i_payload_kind,
    input  logic                  i_marker,
    input  logic [31:0]           i_media_time,
    input  logic [15:0]           i_payload_bytes,
    input  logic [15:0]           i_buffer_handle,
    // result
    output logic                  o_strobe,
    output logic [2:0]            o_status,
    output logic [31:0]           o_out_source_id,
    output logic [15:0]           o_out_sequence,
    output logic [7:0]            o_out_type_byte,
    output logic [31:0]           o_out_media_time,
    output logic [15:0]           o_original_sequence,
    output logic [15:0]           o_out_buffer_handle,
    output logic [15:0]           o_out_payload_bytes,
    output logic [31:0]           o_packets_sent,
    output logic [31:0]           o_octets_sent
);

    localparam int IDXW = $clog2(CACHE_DEPTH);
    localparam bit IS_POW2 = ((CACHE_DEPTH & (CACHE_DEPTH - 1)) == 0);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CACHE_DEPTH);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CACHE_DEPTH - 1);
    localparam int EW = $bits(t_cache_entry);

    // state machine
    t_state r_state, n_state;

    // configuration registers
    logic [31:0] r_local_ssrc, r_rtx_ssrc, r_media_table, r_rtx_table;
    logic        r_rtx_en;
    logic [7:0]  r_window;
    logic [15:0] r_rtx_first;

    // captured request
    logic        r_op;
    logic [31:0] r_ssrc;
    logic [15:0] r_seq;
    logic [6:0]  r_kind;
    logic        r_mark;
    logic [31:0] r_time;
    logic [15:0] r_plen;
    logic [15:0] r_handle;

    // slot computation
    logic [15:0]     r_quo;
    logic [IDXW-1:0] r_slot;
    logic [IDXW-1:0] r_clr_idx;

    // sender state
    logic        r_sent_any, n_sent_any;
    logic [15:0] r_prev_sent, n_prev_sent;
    logic        r_rtx_any, n_rtx_any;
    logic [15:0] r_last_rtx, n_last_rtx;
    logic [31:0] r_pkt_cnt, n_pkt_cnt;
    logic [31:0] r_oct_cnt, n_oct_cnt;
    logic [15:0] r_newest, n_newest;

    // result registers
    logic        r_strobe, n_strobe;
    t_status     r_status, n_status;
    logic [31:0] r_res_ssrc, n_res_ssrc;
    logic [15:0] r_res_seq, n_res_seq;
    logic [7:0]  r_res_type, n_res_type;
    logic [31:0] r_res_time, n_res_time;
    logic [15:0] r_res_orig, n_res_orig;
    logic [15:0] r_res_handle, n_res_handle;
    logic [15:0] r_res_len, n_res_len;
    logic [31:0] r_res_pkts, n_res_pkts;
    logic [31:0] r_res_octs, n_res_octs;

    // ram controls
    logic            cache_we, valid_we, valid_wdata, ram_re, rd_valid;
    logic [IDXW-1:0] ram_raddr, valid_waddr;
    t_cache_entry    cache_wdata, rd_entry;
    logic [EW-1:0]   rd_bits;

    // datapath helpers
    logic            accept;
    logic [IDXW-1:0] in_slot, rem_slot;
    logic [47:0]     q_prod;
    logic [31:0]     qd_prod;
    logic [16:0]     rem_raw, rem_fix;
    logic [6:0]      lk_type;
    t_type_match     lk;
    logic [15:0]     seq_next, age, rtx_seq;
    logic [16:0]     len_sum;
    logic [15:0]     rtx_len;
    logic            cache_hit;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign in_slot = i_sequence_req[IDXW-1:0];

    // sequence modulo depth by reciprocal multiply and one correction
    assign q_prod   = {16'd0, r_seq} * {16'd0, RECIP};
    assign qd_prod  = {16'd0, r_quo} * 32'(CACHE_DEPTH);
    assign rem_raw  = {1'b0, r_seq} - {1'b0, qd_prod[15:0]};
    assign rem_fix  = (rem_raw >= 17'(CACHE_DEPTH)) ? rem_raw - 17'(CACHE_DEPTH) : rem_raw;
    assign rem_slot = rem_fix[IDXW-1:0];

    // cache read address
    assign ram_raddr = IS_POW2 ? in_slot : rem_slot;
    assign ram_re    = IS_POW2 ? accept : (r_state == ST_ADDR);

    // valid bits are cleared by the pass after reset
    assign valid_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_slot;
    assign valid_wdata = (r_state != ST_CLEAR);
    assign valid_we    = (r_state == ST_CLEAR) || cache_we;

    rtps_ram #(
        .WIDTH (1),
        .DEPTH (CACHE_DEPTH)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (valid_we),
        .i_waddr (valid_waddr),
        .i_wdata (valid_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_valid)
    );

    rtps_ram #(
        .WIDTH (EW),
        .DEPTH (CACHE_DEPTH)
    ) u_cache_ram (
        .i_clk   (i_clk),
        .i_we    (cache_we),
        .i_waddr (r_slot),
        .i_wdata (cache_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_bits)
    );

    assign rd_entry = t_cache_entry'(rd_bits);

    // one lookup serves both the send type and the cached type
    assign lk_type = r_op ? rd_entry.ptype : r_kind;

    rtps_type_lookup #(
        .TYPE_SLOTS (TYPE_SLOTS)
    ) u_type_lookup (
        .i_media_table (r_media_table),
        .i_rtx_table   (r_rtx_table),
        .i_ptype       (lk_type),
        .o_match       (lk)
    );

    assign seq_next  = r_prev_sent + 16'd1;
    assign age       = r_newest - r_seq;
    assign rtx_seq   = (r_rtx_any ? r_last_rtx : r_rtx_first) + 16'd1;
    assign len_sum   = {1'b0, rd_entry.length} + 17'd2;
    assign rtx_len   = len_sum[16] ? 16'hFFFF : len_sum[15:0];
    assign cache_hit = rd_valid && (rd_entry.seq == r_seq) && (age <= {8'd0, r_window})
                       && lk.rtx_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_idx == LAST_IDX) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = IS_POW2 ? ST_EXEC : ST_QUOT;
            ST_QUOT:  n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // execute step: checks, state update, cache write and result
    always_comb begin
        n_sent_any   = r_sent_any;
        n_prev_sent  = r_prev_sent;
        n_rtx_any    = r_rtx_any;
        n_last_rtx   = r_last_rtx;
        n_pkt_cnt    = r_pkt_cnt;
        n_oct_cnt    = r_oct_cnt;
        n_newest     = r_newest;
        n_strobe     = 1'b0;
        n_status     = r_status;
        n_res_ssrc   = r_res_ssrc;
        n_res_seq    = r_res_seq;
        n_res_type   = r_res_type;
        n_res_time   = r_res_time;
        n_res_orig   = r_res_orig;
        n_res_handle = r_res_handle;
        n_res_len    = r_res_len;
        n_res_pkts   = r_res_pkts;
        n_res_octs   = r_res_octs;
        cache_we     = 1'b0;
        cache_wdata  = '{seq: r_seq, marker: r_mark, ptype: r_kind, media_time: r_time,
                         handle: r_handle, length: r_plen};
        unique case (r_state)
            ST_EXEC: begin
                n_strobe     = 1'b1;
                n_res_ssrc   = '0;
                n_res_seq    = '0;
                n_res_type   = '0;
                n_res_time   = '0;
                n_res_orig   = '0;
                n_res_handle = '0;
                n_res_len    = '0;
                if (!r_op) begin
                    if (r_ssrc != r_local_ssrc) begin
                        n_status = STAT_SSRC_MISMATCH;
                    end else if (!lk.known) begin
                        n_status = STAT_UNKNOWN_TYPE;
                    end else if (r_sent_any && (r_seq != seq_next)) begin
                        n_status = STAT_SEQ_GAP;
                    end else begin
                        n_status     = STAT_SENT;
                        cache_we     = r_rtx_en && lk.rtx_valid;
                        if (cache_we) n_newest = r_seq;
                        n_pkt_cnt    = r_pkt_cnt + 32'd1;
                        n_oct_cnt    = r_oct_cnt + {16'd0, r_plen};
                        n_prev_sent  = r_seq;
                        n_sent_any   = 1'b1;
                        n_res_ssrc   = r_ssrc;
                        n_res_seq    = r_seq;
                        n_res_type   = {r_mark, r_kind};
                        n_res_time   = r_time;
                        n_res_handle = r_handle;
                        n_res_len    = r_plen;
                    end
                end else if (!r_rtx_en) begin
                    n_status = STAT_RTX_OFF;
                end else if (!cache_hit) begin
                    n_status = STAT_NOT_CACHED;
                end else begin
                    n_status     = STAT_RTX_SENT;
                    n_rtx_any    = 1'b1;
                    n_last_rtx   = rtx_seq;
                    n_res_ssrc   = r_rtx_ssrc;
                    n_res_seq    = rtx_seq;
                    n_res_type   = {rd_entry.marker, lk.rtx_type};
                    n_res_time   = rd_entry.media_time;
                    n_res_orig   = r_seq;
                    n_res_handle = rd_entry.handle;
                    n_res_len    = rtx_len;
                end
                n_res_pkts = n_pkt_cnt;
                n_res_octs = n_oct_cnt;
            end
            default: ;
        endcase
    end

    // control and sender state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_sent_any  <= 1'b0;
            r_prev_sent <= '0;
            r_rtx_any   <= 1'b0;
            r_last_rtx  <= '0;
            r_pkt_cnt   <= '0;
            r_oct_cnt   <= '0;
            r_newest    <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sent_any  <= n_sent_any;
            r_prev_sent <= n_prev_sent;
            r_rtx_any   <= n_rtx_any;
            r_last_rtx  <= n_last_rtx;
            r_pkt_cnt   <= n_pkt_cnt;
            r_oct_cnt   <= n_oct_cnt;
            r_newest    <= n_newest;
            r_strobe    <= n_strobe;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ssrc  <= '0;
            r_rtx_ssrc    <= '0;
            r_rtx_en      <= 1'b0;
            r_window      <= '0;
            r_media_table <= '0;
            r_rtx_table   <= '0;
            r_rtx_first   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOCAL_SSRC:   r_local_ssrc  <= i_cfg_data;
                REG_RTX_SSRC:     r_rtx_ssrc    <= i_cfg_data;
                REG_RTX_ENABLED:  r_rtx_en      <= i_cfg_data[0];
                REG_CACHE_WINDOW: r_window      <= i_cfg_data[7:0];
                REG_MEDIA_TABLE:  r_media_table <= i_cfg_data;
                REG_RTX_TABLE:    r_rtx_table   <= i_cfg_data;
                REG_RTX_FIRST:    r_rtx_first   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // request capture, slot and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_ssrc   <= i_source_id;
            r_seq    <= i_sequence_req;
            r_kind   <= i_payload_kind;
            r_mark   <= i_marker;
            r_time   <= i_media_time;
            r_plen   <= i_payload_bytes;
            r_handle <= i_buffer_handle;
            r_slot   <= in_slot;
        end
        if (r_state == ST_QUOT) begin
            r_quo <= q_prod[47:32];
        end
        if (r_state == ST_ADDR) begin
            r_slot <= rem_slot;
        end
        r_status     <= n_status;
        r_res_ssrc   <= n_res_ssrc;
        r_res_seq    <= n_res_seq;
        r_res_type   <= n_res_type;
        r_res_time   <= n_res_time;
        r_res_orig   <= n_res_orig;
        r_res_handle <= n_res_handle;
        r_res_len    <= n_res_len;
        r_res_pkts   <= n_res_pkts;
        r_res_octs   <= n_res_octs;
    end

    assign o_strobe            = r_strobe;
    assign o_status            = r_status;
    assign o_out_source_id     = r_res_ssrc;
    assign o_out_sequence      = r_res_seq;
    assign o_out_type_byte     = r_res_type;
    assign o_out_media_time    = r_res_time;
    assign o_original_sequence = r_res_orig;
    assign o_out_buffer_handle = r_res_handle;
    assign o_out_payload_bytes = r_res_len;
    assign o_packets_sent      = r_res_pkts;
    assign o_octets_sent       = r_res_octs;

    // a result follows every execute step and nothing else
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> o_strobe)
        else $error("no result after execute step");

    a_strobe_only_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EXEC))
        else $error("result without execute step");

    // an accepted send bumps the packet counter by one
    a_send_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STAT_SENT)) |-> (o_packets_sent == $past(r_pkt_cnt) + 32'd1))
        else $error("packet counter not advanced on send");

    // rtx off status only while retransmission is disabled
    a_rtx_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STAT_RTX_OFF)) |-> !r_rtx_en)
        else $error("rtx off reported while enabled");

endmodule

/* rtl/rtps_ram.sv */
// generic single write port ram with registered read
module rtps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rtps_type_lookup.sv */
// payload type lookup in the media and rtx type tables
module rtps_type_lookup
    import rtps_pkg::*;
#(
    parameter int TYPE_SLOTS = TYPE_SLOTS_DEF
) (
    input  logic [31:0]  i_media_table,
    input  logic [31:0]  i_rtx_table,
    input  logic [6:0]   i_ptype,
    output t_type_match  o_match
);

    // scan slots from the top so the lowest matching slot with a valid rtx entry wins the rtx type
    always_comb begin
        logic [7:0] m_byte;
        logic [7:0] r_byte;
        int         b;
        o_match = '0;
        for (int i = TYPE_SLOTS - 1; i >= 0; i--) begin
            b      = (i < TABLE_BYTES) ? i : 0;
            m_byte = (i < TABLE_BYTES) ? i_media_table[8*b +: 8] : 8'h00;
            r_byte = (i < TABLE_BYTES) ? i_rtx_table[8*b +: 8] : 8'h00;
            if (m_byte[7] && (m_byte[6:0] == i_ptype)) begin
                o_match.known = 1'b1;
                if (r_byte[7]) begin
                    o_match.rtx_valid = 1'b1;
                    o_match.rtx_type  = r_byte[6:0];
                end
            end
        end
    end

endmodule

/* tb/rtp_sender_with_rtx_cache_top_tb.sv */
// testbench for the rtp sender with rtx cache: directed and random packet descriptors
`timescale 1ns / 100ps

module rtp_sender_with_rtx_cache_top_tb;
    import rtps_pkg::*;

    localparam int CACHE_SLOTS = CACHE_DEPTH_DEF;
    localparam int MAP_SLOTS   = (TYPE_SLOTS_DEF < TABLE_BYTES) ? TYPE_SLOTS_DEF : TABLE_BYTES;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 200;

    // request opcodes
    localparam logic OP_SEND    = 1'b0;
    localparam logic OP_RTX_REQ = 1'b1;

    // one packet descriptor
    typedef struct packed {
        logic        op;
        logic [31:0] ssrc;
        logic [15:0] seq;
        logic [6:0]  kind;
        logic        mark;
        logic [31:0] mtime;
        logic [15:0] plen;
        logic [15:0] handle;
    } t_pkt_desc;

    // one emitted packet with counters
    typedef struct packed {
        t_status     status;
        logic [31:0] ssrc;
        logic [15:0] seq;
        logic [7:0]  type_byte;
        logic [31:0] mtime;
        logic [15:0] orig_seq;
        logic [15:0] handle;
        logic [15:0] plen;
        logic [31:0] pkts;
        logic [31:0] octets;
    } t_pkt_out;

    // dut connections
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_operation = 1'b0;
    logic [31:0]           i_source_id = '0;
    logic [15:0]           i_sequence_req = '0;
    logic [6:0]            i_payload_kind = '0;
    logic                  i_marker = 1'b0;
    logic [31:0]           i_media_time = '0;
    logic [15:0]           i_payload_bytes = '0;
    logic [15:0]           i_buffer_handle = '0;
    logic                  o_strobe;
    logic [2:0]            o_status;
    logic [31:0]           o_out_source_id;
    logic [15:0]           o_out_sequence;
    logic [7:0]            o_out_type_byte;
    logic [31:0]           o_out_media_time;
    logic [15:0]           o_original_sequence;
    logic [15:0]           o_out_buffer_handle;
    logic [15:0]           o_out_payload_bytes;
    logic [31:0]           o_packets_sent;
    logic [31:0]           o_octets_sent;

    // register copies
    bit [31:0] cfg_local_ssrc, cfg_rtx_ssrc, cfg_media_tbl, cfg_rtx_tbl;
    bit        cfg_rtx_on;
    bit [7:0]  cfg_window;
    bit [15:0] cfg_rtx_base;

    // sender state copy
    bit        have_sent, have_rtx;
    bit [15:0] prev_sent_seq, last_rtx_seq, newest_cached;
    bit [31:0] pkt_count, octet_count;
    bit        cache_vld    [CACHE_SLOTS];
    bit [15:0] cache_seq    [CACHE_SLOTS];
    bit        cache_mark   [CACHE_SLOTS];
    bit [6:0]  cache_kind   [CACHE_SLOTS];
    bit [31:0] cache_time   [CACHE_SLOTS];
    bit [15:0] cache_handle [CACHE_SLOTS];
    bit [15:0] cache_len    [CACHE_SLOTS];

    // stimulus and scoreboard
    t_pkt_desc desc_q[$];
    t_pkt_out  want_pkts[$];
    t_pkt_desc cur_desc;
    int        idle_pct = 0;
    bit        hold_for_drain = 1'b0;
    bit [15:0] gen_seq;
    int        phase_cnt = 0;
    int        accepted_cnt = 0;
    int        checked_cnt = 0;
    int        mismatches = 0;
    int        stall_cnt = 0;
    int        status_hits[8];

    rtp_sender_with_rtx_cache_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .start               (start),
        .busy                (busy),
        .i_operation         (i_operation),
        .i_source_id         (i_source_id),
        .i_sequence_req      (i_sequence_req),
        .i_payload_kind      (i_payload_kind),
        .i_marker            (i_marker),
        .i_media_time        (i_media_time),
        .i_payload_bytes     (i_payload_bytes),
        .i_buffer_handle     (i_buffer_handle),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_out_source_id     (o_out_source_id),
        .o_out_sequence      (o_out_sequence),
        .o_out_type_byte     (o_out_type_byte),
        .o_out_media_time    (o_out_media_time),
        .o_original_sequence (o_original_sequence),
        .o_out_buffer_handle (o_out_buffer_handle),
        .o_out_payload_bytes (o_out_payload_bytes),
        .o_packets_sent      (o_packets_sent),
        .o_octets_sent       (o_octets_sent)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // payload type present in a valid media slot
    function automatic bit media_known(logic [6:0] kind);
        logic [7:0] m;
        for (int s = 0; s < MAP_SLOTS; s++) begin
            m = cfg_media_tbl[8*s +: 8];
            if (m[7] && m[6:0] == kind) return 1'b1;
        end
        return 1'b0;
    endfunction

    // first matching media slot with a valid rtx slot: {found, rtx type}
    function automatic logic [7:0] rtx_lookup(logic [6:0] kind);
        logic [7:0] m, r;
        for (int s = 0; s < MAP_SLOTS; s++) begin
            m = cfg_media_tbl[8*s +: 8];
            r = cfg_rtx_tbl[8*s +: 8];
            if (m[7] && m[6:0] == kind && r[7]) return {1'b1, r[6:0]};
        end
        return 8'd0;
    endfunction

    // apply one descriptor to the sender state and return the packet it emits
    function automatic t_pkt_out sender_step(t_pkt_desc d);
        t_pkt_out   o;
        logic [7:0] map;
        logic [15:0] age, base;
        logic [16:0] len;
        int         slot;
        o = '0;
        slot = int'(d.seq) % CACHE_SLOTS;
        if (d.op == OP_SEND) begin
            if (d.ssrc != cfg_local_ssrc) begin
                o.status = STAT_SSRC_MISMATCH;
            end else if (!media_known(d.kind)) begin
                o.status = STAT_UNKNOWN_TYPE;
            end else if (have_sent && d.seq != prev_sent_seq + 16'd1) begin
                o.status = STAT_SEQ_GAP;
            end else begin
                o.status = STAT_SENT;
                map = rtx_lookup(d.kind);
                // cache only with rtx on and a mapping for the type
                if (cfg_rtx_on && map[7]) begin
                    cache_vld[slot]    = 1'b1;
                    cache_seq[slot]    = d.seq;
                    cache_mark[slot]   = d.mark;
                    cache_kind[slot]   = d.kind;
                    cache_time[slot]   = d.mtime;
                    cache_handle[slot] = d.handle;
                    cache_len[slot]    = d.plen;
                    newest_cached      = d.seq;
                end
                pkt_count     = pkt_count + 32'd1;
                octet_count   = octet_count + d.plen;
                prev_sent_seq = d.seq;
                have_sent     = 1'b1;
                o.ssrc        = d.ssrc;
                o.seq         = d.seq;
                o.type_byte   = {d.mark, d.kind};
                o.mtime       = d.mtime;
                o.handle      = d.handle;
                o.plen        = d.plen;
            end
        end else if (!cfg_rtx_on) begin
            o.status = STAT_RTX_OFF;
        end else begin
            age = newest_cached - d.seq;
            map = rtx_lookup(cache_kind[slot]);
            if (!cache_vld[slot] || cache_seq[slot] != d.seq || age > cfg_window || !map[7]) begin
                o.status = STAT_NOT_CACHED;
            end else begin
                base = have_rtx ? last_rtx_seq : cfg_rtx_base;
                len  = {1'b0, cache_len[slot]} + 17'd2;
                if (len > 17'h0FFFF) len = 17'h0FFFF;
                have_rtx     = 1'b1;
                last_rtx_seq = base + 16'd1;
                o.status     = STAT_RTX_SENT;
                o.ssrc       = cfg_rtx_ssrc;
                o.seq        = last_rtx_seq;
                o.type_byte  = {cache_mark[slot], map[6:0]};
                o.mtime      = cache_time[slot];
                o.orig_seq   = d.seq;
                o.handle     = cache_handle[slot];
                o.plen       = len[15:0];
            end
        end
        o.pkts   = pkt_count;
        o.octets = octet_count;
        return o;
    endfunction

    // descriptor with every field random but the opcode, which is a send
    function automatic t_pkt_desc rand_desc();
        t_pkt_desc d;
        d.op     = OP_SEND;
        d.ssrc   = $urandom();
        d.seq    = 16'($urandom());
        d.kind   = 7'($urandom());
        d.mark   = 1'($urandom());
        d.mtime  = $urandom();
        d.plen   = 16'($urandom());
        d.handle = 16'($urandom());
        return d;
    endfunction

    function automatic t_pkt_desc send_desc(logic [31:0] ssrc, logic [15:0] seq,
                                            logic [6:0] kind, logic mark, logic [31:0] mtime,
                                            logic [15:0] plen, logic [15:0] handle);
        t_pkt_desc d;
        d = '{OP_SEND, ssrc, seq, kind, mark, mtime, plen, handle};
        return d;
    endfunction

    function automatic t_pkt_desc req_desc(logic [15:0] seq);
        t_pkt_desc d;
        d     = rand_desc();
        d.op  = OP_RTX_REQ;
        d.seq = seq;
        return d;
    endfunction

    // append one descriptor to the pending queue
    task automatic queue_desc(t_pkt_desc d);
        desc_q = {desc_q, d};
    endtask

    // write all registers from the local copies, block is idle here
    task automatic apply_cfg();
        t_cfg_reg r;
        r = r.first();
        @(posedge i_clk);
        repeat (r.num()) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r;
            case (r)
                REG_LOCAL_SSRC:   i_cfg_data <= cfg_local_ssrc;
                REG_RTX_SSRC:     i_cfg_data <= cfg_rtx_ssrc;
                REG_RTX_ENABLED:  i_cfg_data <= {31'd0, cfg_rtx_on};
                REG_CACHE_WINDOW: i_cfg_data <= {24'd0, cfg_window};
                REG_MEDIA_TABLE:  i_cfg_data <= cfg_media_tbl;
                REG_RTX_TABLE:    i_cfg_data <= cfg_rtx_tbl;
                REG_RTX_FIRST:    i_cfg_data <= {16'd0, cfg_rtx_base};
                default:          i_cfg_data <= '0;
            endcase
            @(posedge i_clk);
            r = r.next();
        end
        i_cfg_we <= 1'b0;
        phase_cnt++;
        @(negedge i_clk);
    endtask

    // wait until every request went in and every packet came back
    task automatic wait_idle();
        while (desc_q.size() != 0 || start || want_pkts.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // random register setting for one phase, extremes on some phases
    task automatic random_cfg(int k);
        cfg_local_ssrc = (k == 3) ? 32'd0 : $urandom();
        cfg_rtx_ssrc   = (k == 1) ? 32'hFFFF_FFFF : $urandom();
        cfg_rtx_on     = ($urandom_range(0, 7) != 0);
        case (k % 3)
            0:       cfg_window = 8'hFF;
            1:       cfg_window = 8'($urandom_range(0, 255));
            default: cfg_window = 8'($urandom_range(0, 16));
        endcase
        cfg_media_tbl = $urandom();
        cfg_rtx_tbl   = $urandom();
        for (int s = 0; s < TABLE_BYTES; s++) begin
            cfg_media_tbl[8*s+7] = ($urandom_range(0, 3) != 0);
            cfg_rtx_tbl[8*s+7]   = ($urandom_range(0, 3) != 0);
        end
        cfg_media_tbl[7] = 1'b1;
        cfg_rtx_base = 16'($urandom());
    endtask

    // mostly in-order sends and recent retransmit requests, some noise
    task automatic queue_random(int count);
        t_pkt_desc  d;
        int         pick;
        logic [6:0] kinds[$];
        logic [7:0] m;
        for (int s = 0; s < MAP_SLOTS; s++) begin
            m = cfg_media_tbl[8*s +: 8];
            if (m[7]) kinds = {kinds, m[6:0]};
        end
        repeat (count) begin
            d    = rand_desc();
            pick = $urandom_range(0, 99);
            if (kinds.size() != 0) d.kind = kinds[$urandom_range(0, kinds.size() - 1)];
            if (pick < 55) begin
                // well-formed send
                d.ssrc = cfg_local_ssrc;
                d.seq  = gen_seq;
                gen_seq++;
                if ($urandom_range(0, 15) == 0) begin
                    d.plen = ($urandom_range(0, 1) == 0) ? 16'd0
                             : 16'hFFFF - 16'($urandom_range(0, 2));
                end else begin
                    d.plen = 16'($urandom_range(0, 65533));
                end
            end else if (pick < 82) begin
                // request around the retrievable window
                d.op  = OP_RTX_REQ;
                d.seq = gen_seq - 16'd1 - 16'($urandom_range(0, int'(cfg_window) + 3));
            end else if (pick < 88) begin
                d.op = OP_RTX_REQ;
            end else begin
                // broken send
                d.ssrc = cfg_local_ssrc;
                d.seq  = gen_seq;
                case ($urandom_range(0, 2))
                    0: d.ssrc = cfg_local_ssrc ^ (32'd1 << $urandom_range(0, 31));
                    1: begin
                        d.kind = 7'($urandom());
                        if (media_known(d.kind)) gen_seq++;
                    end
                    default: d.seq = gen_seq + 16'($urandom_range(1, 400));
                endcase
            end
            queue_desc(d);
        end
    endtask

    // compare one field of an emitted packet
    task automatic cmp_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on packet %0d, %s: expected %h, got %h",
                         checked_cnt, what, want, got);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_for_drain && want_pkts.size() == 0) hold_for_drain = 1'b0;
            if (start && !busy) begin
                want_pkts = {want_pkts, sender_step(cur_desc)};
                accepted_cnt++;
                if ($urandom_range(0, 59) == 0) hold_for_drain = 1'b1;
            end
            if (!(start && busy)) begin
                if (desc_q.size() != 0 && !hold_for_drain && $urandom_range(0, 99) >= idle_pct) begin
                    cur_desc        = desc_q.pop_front();
                    i_operation     <= cur_desc.op;
                    i_source_id     <= cur_desc.ssrc;
                    i_sequence_req  <= cur_desc.seq;
                    i_payload_kind  <= cur_desc.kind;
                    i_marker        <= cur_desc.mark;
                    i_media_time    <= cur_desc.mtime;
                    i_payload_bytes <= cur_desc.plen;
                    i_buffer_handle <= cur_desc.handle;
                    start           <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_pkt_out want;
        if (i_rst_n && o_strobe === 1'b1) begin
            checked_cnt++;
            if (want_pkts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected packet %0d with status %0d", checked_cnt, o_status);
            end else begin
                want = want_pkts.pop_front();
                status_hits[want.status]++;
                cmp_field("status", want.status, o_status);
                cmp_field("source id", want.ssrc, o_out_source_id);
                cmp_field("sequence", want.seq, o_out_sequence);
                cmp_field("type byte", want.type_byte, o_out_type_byte);
                cmp_field("media time", want.mtime, o_out_media_time);
                cmp_field("original sequence", want.orig_seq, o_original_sequence);
                cmp_field("buffer handle", want.handle, o_out_buffer_handle);
                cmp_field("payload bytes", want.plen, o_out_payload_bytes);
                cmp_field("packets sent", want.pkts, o_packets_sent);
                cmp_field("octets sent", want.octets, o_octets_sent);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) stall_cnt = 0;
        else stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // reset, directed phases, random phases, end of run
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);

        // directed: wrap, extremes, saturation, window edges
        idle_pct       = 6;
        cfg_local_ssrc = 32'hFFFF_FFFF;
        cfg_rtx_ssrc   = 32'd0;
        cfg_rtx_on     = 1'b1;
        cfg_window     = 8'hFF;
        cfg_media_tbl  = 32'hE1FF_E1E0;
        cfg_rtx_tbl    = 32'hFF80_65E4;
        cfg_rtx_base   = 16'hFFFF;
        apply_cfg();
        queue_desc(req_desc(16'h0100));
        queue_desc(send_desc(32'd0, 16'd100, 7'd96, 1'b0, 32'd7, 16'd10, 16'd3));
        queue_desc(send_desc(cfg_local_ssrc, 16'd100, 7'd5, 1'b0, 32'd7, 16'd10, 16'd3));
        queue_desc(send_desc(cfg_local_ssrc, 16'd65533, 7'd96, 1'b1, 32'hFFFF_FFFF,
                             16'd65533, 16'hFFFF));
        queue_desc(send_desc(cfg_local_ssrc, 16'd65534, 7'd97, 1'b0, 32'd0, 16'd0, 16'd0));
        queue_desc(send_desc(cfg_local_ssrc, 16'd65535, 7'd127, 1'b1, 32'h1234_5678,
                             16'd1000, 16'hABCD));
        queue_desc(send_desc(cfg_local_ssrc, 16'd0, 7'd96, 1'b0, 32'd0, 16'd65534, 16'd1));
        queue_desc(send_desc(cfg_local_ssrc, 16'd5, 7'd96, 1'b0, 32'd0, 16'd1, 16'd1));
        queue_desc(req_desc(16'd65533));
        queue_desc(req_desc(16'd65534));
        queue_desc(req_desc(16'd65535));
        queue_desc(req_desc(16'd0));
        queue_desc(req_desc(16'd1));
        queue_desc(send_desc(cfg_local_ssrc, 16'd1, 7'd96, 1'b1, 32'h8000_0001,
                             16'hFFFF, 16'h5A5A));
        queue_desc(req_desc(16'd1));
        queue_desc(req_desc(16'h0101));
        wait_idle();

        // mapping removed for some types, window of zero
        cfg_rtx_ssrc  = 32'hFFFF_FFFF;
        cfg_window    = 8'd0;
        cfg_media_tbl = 32'hE17F_E1E0;
        cfg_rtx_tbl   = 32'h0000_00E4;
        cfg_rtx_base  = 16'd0;
        apply_cfg();
        queue_desc(req_desc(16'd65535));
        queue_desc(req_desc(16'd0));
        queue_desc(req_desc(16'd1));
        queue_desc(send_desc(cfg_local_ssrc, 16'd2, 7'd127, 1'b0, 32'd9, 16'd9, 16'd9));
        queue_desc(send_desc(cfg_local_ssrc, 16'd2, 7'd97, 1'b1, 32'd9, 16'd9, 16'd9));
        queue_desc(req_desc(16'd2));
        wait_idle();

        // retransmission switched off
        cfg_rtx_on = 1'b0;
        apply_cfg();
        queue_desc(req_desc(16'd1));
        queue_desc(send_desc(cfg_local_ssrc, 16'd3, 7'd96, 1'b0, 32'd4, 16'd4, 16'd4));
        wait_idle();

        // random phases under three idling regimes
        for (int k = 0; k < RAND_PHASES; k++) begin
            idle_pct = (k < 2) ? 6 : (k < 4) ? 72 : 0;
            random_cfg(k);
            apply_cfg();
            gen_seq = prev_sent_seq + 16'd1;
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (6) @(negedge i_clk);
        if (want_pkts.size() != 0) begin
            $display("%0d expected packets never came out", want_pkts.size());
            mismatches += want_pkts.size();
        end
        $display("covered %0d descriptors in %0d register settings: %0d sent, %0d rejected sends",
                 accepted_cnt, phase_cnt, status_hits[STAT_SENT],
                 status_hits[STAT_SSRC_MISMATCH] + status_hits[STAT_UNKNOWN_TYPE]
                 + status_hits[STAT_SEQ_GAP]);
        $display("retransmits %0d, not cached %0d, rtx off %0d, %0d packets checked, %0d mismatches",
                 status_hits[STAT_RTX_SENT], status_hits[STAT_NOT_CACHED],
                 status_hits[STAT_RTX_OFF], checked_cnt, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/rtps_pkg.sv
rtl/rtps_ram.sv
rtl/rtps_type_lookup.sv
rtl/rtp_sender_with_rtx_cache_top.sv
tb/rtp_sender_with_rtx_cache_top_tb.sv
